### rtl/core/bppg_pkg.sv
// Shared types, constants and arithmetic helpers for the PPG Bayer demosaic.
package bppg_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int STORED_LINES = 6;
  localparam int XW           = $clog2(MAX_WIDTH);
  localparam int LSW          = 8 * STORED_LINES;
  localparam int DIV_STEPS    = 16;
  localparam int CFG_IW       = 1;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef logic [6:0][6:0][7:0] win_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       grn_step;
    logic [2:0] k;
    logic       dsel;
    logic       hue_set;
    logic       hue_step;
    logic       hue_idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic green_site;
    logic hue_done;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] absd(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] clamp8(logic signed [17:0] v);
    logic [7:0] r;
    if (v < 18'sd0) r = 8'd0;
    else if (v > 18'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  function automatic logic is_interior(logic signed [17:0] r, logic signed [17:0] c,
                                       logic [15:0] h, logic [10:0] w);
    logic signed [17:0] hs;
    logic signed [17:0] ws;
    hs = $signed({2'b0, h});
    ws = $signed({7'b0, w});
    return (r >= 18'sd2) && (r <= hs - 18'sd3) && (c >= 18'sd2) && (c <= ws - 18'sd3);
  endfunction

  // Directional green at the non-green site at window row rc, column cc.
  function automatic logic [7:0] green_interp(win_t w, logic [2:0] rc, logic [2:0] cc);
    logic [7:0]         x, gn, gs, gw, ge, xn, xs, xw, xe, dv, dh;
    logic [9:0]         dn, ds, de, dw;
    logic signed [11:0] v;
    logic signed [11:0] q;
    logic [7:0]         r;
    x  = w[rc][cc];
    gn = w[rc - 3'd1][cc];
    gs = w[rc + 3'd1][cc];
    gw = w[rc][cc - 3'd1];
    ge = w[rc][cc + 3'd1];
    xn = w[rc - 3'd2][cc];
    xs = w[rc + 3'd2][cc];
    xw = w[rc][cc - 3'd2];
    xe = w[rc][cc + 3'd2];
    dv = absd(gn, gs);
    dh = absd(gw, ge);
    dn = {1'b0, absd(x, xn), 1'b0} + {2'b0, dv};
    ds = {1'b0, absd(x, xs), 1'b0} + {2'b0, dv};
    de = {1'b0, absd(x, xe), 1'b0} + {2'b0, dh};
    dw = {1'b0, absd(x, xw), 1'b0} + {2'b0, dh};
    if (dn < de && dn < dw && dn < ds)
      v = $signed({4'b0, gn}) * 12'sd3 + $signed({4'b0, gs}) + $signed({4'b0, x})
          - $signed({4'b0, xn});
    else if (de < dn && de < dw && de < ds)
      v = $signed({4'b0, ge}) * 12'sd3 + $signed({4'b0, gw}) + $signed({4'b0, x})
          - $signed({4'b0, xe});
    else if (dw < de && dw < dn && dw < ds)
      v = $signed({4'b0, gw}) * 12'sd3 + $signed({4'b0, ge}) + $signed({4'b0, x})
          - $signed({4'b0, xw});
    else
      v = $signed({4'b0, gs}) * 12'sd3 + $signed({4'b0, gn}) + $signed({4'b0, x})
          - $signed({4'b0, xs});
    if (v[11]) q = -((-v) >>> 2);
    else q = v >>> 2;
    if (q[11]) r = 8'd0;
    else if (q > 12'sd255) r = 8'd255;
    else r = q[7:0];
    return r;
  endfunction

endpackage

### rtl/core/bayer_ppg_demosaic.sv
// Top level of the streaming PPG Bayer demosaic.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_sample, in_padding
//   out_     output     out_valid / out_ready   out_red, out_green, out_blue, out_end_of_frame
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item with no pixel returns to idle after loading; a border pixel goes to output.
// An interior pixel runs the shared green unit 4 or 5 times and the serial
// 16-step divider once or twice before it goes to output.
// A pixel waits for output while the output register is still full.
// Reset is synchronous; the line stores hold no reset value and need no clearing.
// A finished item waits in the output register while the next item is taken in.
module bayer_ppg_demosaic import bppg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_sample,
  input  logic              in_padding,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              out_end_of_frame,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [15:0]       cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bppg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bppg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .in_padding       (in_padding),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_frame (out_end_of_frame)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("A pending pixel was overwritten.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second item was taken while one is in work.");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("Output became valid without a finished pixel.");

endmodule

### rtl/core/bppg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bppg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bppg_ctrl.sv
// Sequencing state machine for the PPG demosaic.
module bppg_ctrl import bppg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_GRN  = 3'd2;
  localparam logic [2:0] ST_DSEL = 3'd3;
  localparam logic [2:0] ST_HSET = 3'd4;
  localparam logic [2:0] ST_HDIV = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.k       = k_r;
    cmd.hue_idx = idx_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (!sts.emit) begin
          state_nxt = ST_IDLE;
        end else if (!sts.interior) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = sts.green_site ? 3'd1 : 3'd0;
          state_nxt = ST_GRN;
        end
      end
      ST_GRN: begin
        cmd.grn_step = 1'b1;
        if (k_r == 3'd4) begin
          idx_nxt   = 1'b0;
          state_nxt = sts.green_site ? ST_HSET : ST_DSEL;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_DSEL: begin
        cmd.dsel  = 1'b1;
        state_nxt = ST_HSET;
      end
      ST_HSET: begin
        cmd.hue_set = 1'b1;
        state_nxt   = ST_HDIV;
      end
      ST_HDIV: begin
        cmd.hue_step = 1'b1;
        if (sts.hue_done) begin
          if (sts.green_site && !idx_r) begin
            idx_nxt   = 1'b1;
            state_nxt = ST_HSET;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 3'd0;
      idx_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### rtl/core/bppg_dp.sv
// Datapath: counters, line stores, window, green and hue units, output register.
module bppg_dp import bppg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [7:0]        in_sample,
  input  logic              in_padding,
  input  logic              cfg_valid,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              out_end_of_frame
);

  logic [10:0] fw_r;
  logic [15:0] fh_r;
  logic [10:0] w_eff;
  logic [15:0] h_eff;

  logic [XW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [15:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [10:0]   col_inc, ocol_inc;
  logic          emit_now, eof_now;

  logic [7:0]    s_r;
  logic [XW-1:0] x_r;
  logic [15:0]   pr_r;
  logic [XW-1:0] pc_r;
  logic          emit_r, eof_r;

  logic [LSW-1:0] rdata;
  win_t           win_r;
  logic [7:0]     g_r [5];
  logic [7:0]     g0v;
  logic           diag_ne_r;

  logic [2:0]         rc, cc;
  logic signed [17:0] prs, pcs, nr, nc;
  logic [7:0]         gval;
  logic [10:0]        dne, dnw;

  logic               use_a;
  logic [7:0]         l1, l3, v1, v3;
  logic signed [8:0]  dvv, dll, dnn;
  logic signed [17:0] prod, prod_mag;
  logic [8:0]         den_abs;
  logic signed [10:0] t, tq;
  logic [8:0]         avg;
  logic               mono;

  logic        mono_r, neg_r;
  logic [7:0]  den_r, v1_r, alt_r;
  logic [15:0] dq_r;
  logic [7:0]  rem_r;
  logic [4:0]  cnt_r;
  logic [8:0]  rem2;
  logic        div_done;
  logic [7:0]  hue_res;
  logic [7:0]  h_r [2];

  logic       out_valid_r;
  logic [7:0] red_r, green_r, blue_r;
  logic       eofo_r;
  logic [7:0] red_n, green_n, blue_n;

  assign w_eff = (fw_r < 11'd5) ? 11'd5 : ((fw_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : fw_r);
  assign h_eff = (fh_r < 16'd5) ? 16'd5 : fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 11'd640;
      fh_r <= 16'd480;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH) fw_r <= cfg_data[10:0];
      if (cfg_index == REG_FRAME_HEIGHT) fh_r <= cfg_data;
    end
  end

  assign col_inc  = {1'b0, in_col_r} + 11'd1;
  assign ocol_inc = {1'b0, out_col_r} + 11'd1;
  assign emit_now = (in_row_r > 16'd3) || (in_row_r == 16'd3 && in_col_r >= XW'(3));
  assign eof_now  = (out_row_r >= h_eff - 16'd1) && ({1'b0, out_col_r} >= w_eff - 11'd1);

  always_comb begin
    in_col_nxt  = col_inc[XW-1:0];
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (col_inc >= w_eff) begin
      in_col_nxt = '0;
      if (in_row_r != 16'hFFFF) in_row_nxt = in_row_r + 16'd1;
    end
    if (emit_now) begin
      if (eof_now) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (ocol_inc >= w_eff) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 16'd1;
      end else begin
        out_col_nxt = ocol_inc[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      emit_r    <= 1'b0;
    end else if (cmd.accept) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      emit_r    <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r   <= in_padding ? 8'd0 : in_sample;
      x_r   <= in_col_r;
      pr_r  <= out_row_r;
      pc_r  <= out_col_r;
      eof_r <= emit_now && eof_now;
    end
  end

  bppg_ram #(.WIDTH(LSW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (x_r),
    .wdata ({s_r, rdata[LSW-1:8]}),
    .raddr (in_col_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cmd.load) begin
      for (int a = 0; a < 7; a++) begin
        for (int k = 0; k < 6; k++) begin
          win_r[a][k] <= win_r[a][k+1];
        end
      end
      for (int a = 0; a < STORED_LINES; a++) begin
        win_r[a][6] <= rdata[8*a +: 8];
      end
      win_r[6][6] <= s_r;
    end
  end

  assign prs = $signed({2'b0, pr_r});
  assign pcs = $signed({{(18-XW){1'b0}}, pc_r});

  always_comb begin
    rc = 3'd3;
    cc = 3'd3;
    if (sts.green_site) begin
      unique case (cmd.k)
        3'd1:    begin rc = 3'd3; cc = 3'd2; end
        3'd2:    begin rc = 3'd3; cc = 3'd4; end
        3'd3:    begin rc = 3'd2; cc = 3'd3; end
        3'd4:    begin rc = 3'd4; cc = 3'd3; end
        default: begin rc = 3'd3; cc = 3'd3; end
      endcase
    end else begin
      unique case (cmd.k)
        3'd1:    begin rc = 3'd2; cc = 3'd4; end
        3'd2:    begin rc = 3'd4; cc = 3'd2; end
        3'd3:    begin rc = 3'd2; cc = 3'd2; end
        3'd4:    begin rc = 3'd4; cc = 3'd4; end
        default: begin rc = 3'd3; cc = 3'd3; end
      endcase
    end
    nr   = prs + $signed({15'b0, rc}) - 18'sd3;
    nc   = pcs + $signed({15'b0, cc}) - 18'sd3;
    gval = is_interior(nr, nc, h_eff, w_eff) ? green_interp(win_r, rc, cc) : 8'd0;
  end

  assign g0v = sts.green_site ? win_r[3][3] : g_r[0];

  assign dne = {3'b0, absd(win_r[2][4], win_r[4][2])} + {3'b0, absd(win_r[1][5], win_r[3][3])}
             + {3'b0, absd(win_r[3][3], win_r[5][1])} + {3'b0, absd(g_r[1], g0v)}
             + {3'b0, absd(g0v, g_r[2])};
  assign dnw = {3'b0, absd(win_r[2][2], win_r[4][4])} + {3'b0, absd(win_r[1][1], win_r[3][3])}
             + {3'b0, absd(win_r[3][3], win_r[5][5])} + {3'b0, absd(g_r[3], g0v)}
             + {3'b0, absd(g0v, g_r[4])};

  always_ff @(posedge clk) begin
    if (cmd.grn_step) g_r[cmd.k] <= gval;
    if (cmd.dsel) diag_ne_r <= (dne < dnw);
  end

  always_comb begin
    use_a = sts.green_site ? !cmd.hue_idx : diag_ne_r;
    l1    = use_a ? g_r[1] : g_r[3];
    l3    = use_a ? g_r[2] : g_r[4];
    if (sts.green_site) begin
      v1 = use_a ? win_r[3][2] : win_r[2][3];
      v3 = use_a ? win_r[3][4] : win_r[4][3];
    end else begin
      v1 = use_a ? win_r[2][4] : win_r[2][2];
      v3 = use_a ? win_r[4][2] : win_r[4][4];
    end
    mono     = (l1 < g0v && g0v < l3) || (l1 > g0v && g0v > l3);
    dvv      = $signed({1'b0, v3}) - $signed({1'b0, v1});
    dll      = $signed({1'b0, g0v}) - $signed({1'b0, l1});
    dnn      = $signed({1'b0, l3}) - $signed({1'b0, l1});
    prod     = 18'(dvv) * 18'(dll);
    prod_mag = prod[17] ? -prod : prod;
    den_abs  = dnn[8] ? 9'(-dnn) : 9'(dnn);
    t        = $signed({2'b0, g0v, 1'b0}) - $signed({3'b0, l1}) - $signed({3'b0, l3});
    tq       = t[10] ? -((-t) >>> 2) : (t >>> 2);
    avg      = ({1'b0, v1} + {1'b0, v3}) >> 1;
  end

  assign rem2     = {rem_r, dq_r[15]};
  assign div_done = (cnt_r == 5'(DIV_STEPS));
  assign hue_res  = clamp8($signed({10'b0, v1_r})
                    + (neg_r ? -$signed({2'b0, dq_r}) : $signed({2'b0, dq_r})));

  always_ff @(posedge clk) begin
    if (cmd.hue_set) begin
      mono_r <= mono;
      neg_r  <= prod[17] ^ dnn[8];
      den_r  <= den_abs[7:0];
      v1_r   <= v1;
      alt_r  <= clamp8(18'($signed({10'b0, avg[7:0]})) + 18'(tq));
      dq_r   <= prod_mag[15:0];
      rem_r  <= 8'd0;
      cnt_r  <= 5'd0;
    end else if (cmd.hue_step && !div_done) begin
      cnt_r <= cnt_r + 5'd1;
      if (rem2 >= {1'b0, den_r}) begin
        rem_r <= 8'(rem2 - {1'b0, den_r});
        dq_r  <= {dq_r[14:0], 1'b1};
      end else begin
        rem_r <= rem2[7:0];
        dq_r  <= {dq_r[14:0], 1'b0};
      end
    end
    if (cmd.hue_step && sts.hue_done) begin
      h_r[cmd.hue_idx] <= mono_r ? hue_res : alt_r;
    end
  end

  always_comb begin
    red_n   = 8'd0;
    green_n = 8'd0;
    blue_n  = 8'd0;
    if (sts.green_site) begin
      green_n = win_r[3][3];
      if (sts.interior) begin
        if (pr_r[0]) begin
          blue_n = h_r[0];
          red_n  = h_r[1];
        end else begin
          red_n  = h_r[0];
          blue_n = h_r[1];
        end
      end
    end else if (!pr_r[0]) begin
      red_n = win_r[3][3];
      if (sts.interior) begin
        green_n = g_r[0];
        blue_n  = h_r[0];
      end
    end else begin
      blue_n = win_r[3][3];
      if (sts.interior) begin
        green_n = g_r[0];
        red_n   = h_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_r   <= red_n;
      green_r <= green_n;
      blue_r  <= blue_n;
      eofo_r  <= eof_r;
    end
  end

  assign sts.emit       = emit_r;
  assign sts.interior   = is_interior(prs, pcs, h_eff, w_eff);
  assign sts.green_site = pr_r[0] ^ pc_r[0];
  assign sts.hue_done   = !mono_r || div_done;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_end_of_frame = eofo_r;

endmodule
